FILE: src/assert_macros.svh
// assertion macros used by the rtl top
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: src/tpmt_pkg.sv
// types, constants and codes for the timed pending match table
// no dependencies
`default_nettype none

package tpmt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int TICK_W      = 48;
	localparam int ID_W        = 32;
	localparam int CAT_W       = 8;
	localparam int LIFE_W      = 32;

	localparam logic [TICK_W-1:0] TICK_MAX       = '1;
	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 32'd2000;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_PUSH    = 2'd1,
		CMD_CONSUME = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISS    = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic [ID_W-1:0]   aggressor;
		logic [ID_W-1:0]   target;
		logic [CAT_W-1:0]  category;
		logic              head_flag;
		logic [TICK_W-1:0] expiry;
	} record_t;

endpackage

`default_nettype wire

FILE: src/timed_pending_match_table_top.sv
// timed pending match table: record memory, compaction scan and command control
// depends on tpmt_pkg and assert_macros.svh
`default_nettype none

// Usage:
// An item (cmd, aggressor_id, target_id, category_in, head_flag_in) is taken
// at a rising edge with start high and busy low. cmd 0 advances the tick
// counter, cmd 1 pushes a record that lives lifetime_q ticks, cmd 2
// consumes the oldest live record matching target and aggressor.
// Every item gives exactly one result (found, category_out, head_flag_out,
// status), shown for one cycle with done high. The receiver cannot stall.
// Records live in a single-port-read, single-port-write memory kept in age
// order as a compact prefix. Each item sweeps the live records once, one
// memory read per cycle: expired records and the consumed one are dropped
// and the rest rewritten in order behind the read pointer. A push is then
// written at the end of the prefix.
// done is a register loaded from the final done state. busy stays high from
// the accept through that state, so no new item is taken while one is in
// progress, and is low again in the cycle done is high, so the next item can
// be taken at the end of that cycle. lifetime_q is written through cfg_we /
// cfg_wdata while idle: a rule for the user that the block does not enforce.
// Reset empties the table, clears the tick counter and loads a lifetime of
// 2000; no clearing pass is needed since the fill count marks the live range.
module timed_pending_match_table_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [tpmt_pkg::LIFE_W-1:0]     cfg_wdata,
	input  wire                            start,
	output logic                           busy,
	input  wire [1:0]                      cmd,
	input  wire [tpmt_pkg::ID_W-1:0]       aggressor_id,
	input  wire [tpmt_pkg::ID_W-1:0]       target_id,
	input  wire [tpmt_pkg::CAT_W-1:0]      category_in,
	input  wire                            head_flag_in,
	output logic                           done,
	output logic                           found,
	output logic [tpmt_pkg::CAT_W-1:0]     category_out,
	output logic                           head_flag_out,
	output logic [1:0]                     status
);
	import tpmt_pkg::*;

	fsm_t                state_q, state_d;
	logic [TICK_W-1:0]   now_q;
	logic [LIFE_W-1:0]   lifetime_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    wr_ptr_q;
	logic                hit_q;
	logic [CAT_W-1:0]    hit_cat_q;
	logic                hit_head_q;
	cmd_t                cmd_q;
	logic [ID_W-1:0]     aggr_q;
	logic [ID_W-1:0]     targ_q;
	logic [CAT_W-1:0]    cat_q;
	logic                head_q;
	logic                vld_s1;
	record_t             rec_s1;
	logic                done_q;
	logic                found_q;
	logic [CAT_W-1:0]    cat_out_q;
	logic                head_out_q;
	status_t             status_q;
	status_t             status_d;

	record_t             mem [TABLE_DEPTH];

	logic                accept;
	logic                rd_en;
	logic                expired_s1;
	logic                match_s1;
	logic                keep_s1;
	logic                push_ok;
	logic [TICK_W:0]     exp_sum;
	logic [TICK_W-1:0]   push_exp;
	logic                wr_en;
	record_t             wr_data;
	record_t             new_rec;

	assign accept = start && !busy;

	// read the next live record while the sweep runs
	assign rd_en = (state_q == FSM_SCAN) && (rd_ptr_q < count_q);

	// judge the record coming out of memory
	assign expired_s1 = rec_s1.expiry <= now_q;
	assign match_s1   = (cmd_q == CMD_CONSUME) && (targ_q != '0) && !hit_q
		&& (rec_s1.target == targ_q)
		&& ((rec_s1.aggressor == '0) || (rec_s1.aggressor == aggr_q))
		&& !expired_s1;
	assign keep_s1    = vld_s1 && !expired_s1 && !match_s1;

	// push expiry, saturated at the top of the tick range
	assign exp_sum  = {1'b0, now_q} + {{(TICK_W + 1 - LIFE_W){1'b0}}, lifetime_q};
	assign push_exp = exp_sum[TICK_W] ? TICK_MAX : exp_sum[TICK_W-1:0];
	assign push_ok  = (cmd_q == CMD_PUSH) && (targ_q != '0)
		&& (wr_ptr_q < CNT_W'(TABLE_DEPTH));

	always_comb begin
		new_rec.aggressor = aggr_q;
		new_rec.target    = targ_q;
		new_rec.category  = cat_q;
		new_rec.head_flag = head_q;
		new_rec.expiry    = push_exp;
	end

	// survivors go back behind the read pointer, a push lands at the end
	assign wr_en   = ((state_q == FSM_SCAN) && keep_s1) || ((state_q == FSM_DONE) && push_ok);
	assign wr_data = (state_q == FSM_SCAN) ? rec_s1 : new_rec;

	// record memory, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q[ADDR_W-1:0]] <= wr_data;
		end
		rec_s1 <= mem[rd_ptr_q[ADDR_W-1:0]];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and busy
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (!rd_en && !vld_s1) begin
					state_d = FSM_DONE;
				end
			end
			FSM_DONE: begin
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			lifetime_q <= LIFETIME_RESET;
			count_q    <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			hit_q      <= 1'b0;
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				lifetime_q <= cfg_wdata;
			end
			vld_s1 <= rd_en;
			done_q <= (state_q == FSM_DONE);
			case (state_q)
				FSM_IDLE: begin
					if (start) begin
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						hit_q    <= 1'b0;
						if ((cmd_t'(cmd) == CMD_TICK) && (now_q != TICK_MAX)) begin
							now_q <= now_q + 1'b1;
						end
					end
				end
				FSM_SCAN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (keep_s1) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
					if (vld_s1 && match_s1) begin
						hit_q <= 1'b1;
					end
				end
				FSM_DONE: begin
					count_q <= push_ok ? wr_ptr_q + 1'b1 : wr_ptr_q;
				end
				default: begin
					hit_q <= 1'b0;
				end
			endcase
		end
	end

	// result status
	always_comb begin
		case (cmd_q)
			CMD_PUSH: begin
				if (targ_q == '0) begin
					status_d = ST_IGNORED;
				end else if (!push_ok) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_DONE;
				end
			end
			CMD_CONSUME: begin
				status_d = hit_q ? ST_DONE : ST_MISS;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// item payload, hit capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(cmd);
			aggr_q <= aggressor_id;
			targ_q <= target_id;
			cat_q  <= category_in;
			head_q <= head_flag_in;
		end
		if ((state_q == FSM_SCAN) && vld_s1 && match_s1) begin
			hit_cat_q  <= rec_s1.category;
			hit_head_q <= rec_s1.head_flag;
		end
		if (state_q == FSM_DONE) begin
			found_q    <= hit_q;
			cat_out_q  <= hit_q ? hit_cat_q : '0;
			head_out_q <= hit_q && hit_head_q;
			status_q   <= status_d;
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign category_out  = cat_out_q;
	assign head_flag_out = head_out_q;
	assign status        = status_q;

	`include "assert_macros.svh"

	`ASSERT_NEVER(a_count_bound, count_q > CNT_W'(TABLE_DEPTH), "record count above table depth")
	`ASSERT_CLK(a_wr_behind_rd, (state_q == FSM_SCAN) && vld_s1 |-> wr_ptr_q < rd_ptr_q, "compaction write overtook read")
	`ASSERT_CLK(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
	`ASSERT_CLK(a_found_status, done && found |-> status == ST_DONE, "found with non-done status")
	`ASSERT_CLK(a_accept_busy, accept |=> busy && !done, "accepted item did not make block busy")

endmodule

`default_nettype wire

FILE: tb/tpmt_result_checker.sv
// result checker for the timed pending match table: tracks the table contents,
// predicts the result of each accepted item and compares it with the block's output
// depends on tpmt_pkg
`default_nettype none

module tpmt_result_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [tpmt_pkg::LIFE_W-1:0] cfg_wdata,
	input  wire                        start,
	input  wire                        busy,
	input  wire [1:0]                  cmd,
	input  wire [tpmt_pkg::ID_W-1:0]   aggressor_id,
	input  wire [tpmt_pkg::ID_W-1:0]   target_id,
	input  wire [tpmt_pkg::CAT_W-1:0]  category_in,
	input  wire                        head_flag_in,
	input  wire                        done,
	input  wire                        found,
	input  wire [tpmt_pkg::CAT_W-1:0]  category_out,
	input  wire                        head_flag_out,
	input  wire [1:0]                  status,
	output int                         fail_count,
	output int                         pending,
	output int                         items_seen,
	output int                         hit_count,
	output int                         drop_count,
	output int                         purge_count
);
	import tpmt_pkg::*;

	typedef struct {
		logic             found;
		logic [CAT_W-1:0] category;
		logic             head_flag;
		status_t          status;
	} outcome_t;

	// shadow copy of the block state
	logic [TICK_W-1:0] tick_now;
	logic [LIFE_W-1:0] lifetime;
	record_t           live_records[$];
	outcome_t          expected_outcomes[$];
	outcome_t          oldest;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		fail_count++;
	endtask

	// one item through the table: tick, purge of expired records, then the command
	function automatic outcome_t match_table_step(input cmd_t op, input logic [ID_W-1:0] aggr,
			input logic [ID_W-1:0] targ, input logic [CAT_W-1:0] cat, input logic head);
		outcome_t          res;
		record_t           kept[$];
		record_t           rec;
		logic [TICK_W:0]   expiry_sum;
		int                hit;
		res.found     = 1'b0;
		res.category  = '0;
		res.head_flag = 1'b0;
		res.status    = ST_DONE;
		hit = -1;

		// saturating tick counter
		if (op == CMD_TICK && tick_now != TICK_MAX)
			tick_now = tick_now + 1'b1;

		// drop every record whose expiry has been reached, keep age order
		foreach (live_records[i])
			if (live_records[i].expiry > tick_now)
				kept.insert(kept.size(), live_records[i]);
		purge_count += live_records.size() - kept.size();
		live_records = kept;

		case (op)
			CMD_PUSH: begin
				if (targ == '0) begin
					res.status = ST_IGNORED;
				end else if (live_records.size() >= TABLE_DEPTH) begin
					res.status = ST_FULL;
					drop_count++;
				end else begin
					expiry_sum    = {1'b0, tick_now} + lifetime;
					rec.aggressor = aggr;
					rec.target    = targ;
					rec.category  = cat;
					rec.head_flag = head;
					rec.expiry    = (expiry_sum > {1'b0, TICK_MAX}) ? TICK_MAX
						: expiry_sum[TICK_W-1:0];
					live_records.insert(live_records.size(), rec);
				end
			end
			CMD_CONSUME: begin
				// oldest record with the same target and a wildcard or equal aggressor
				if (targ != '0)
					foreach (live_records[i])
						if (hit < 0 && live_records[i].target == targ &&
								(live_records[i].aggressor == '0 ||
								live_records[i].aggressor == aggr))
							hit = i;
				if (hit < 0) begin
					res.status = ST_MISS;
				end else begin
					res.found     = 1'b1;
					res.category  = live_records[hit].category;
					res.head_flag = live_records[hit].head_flag;
					live_records.delete(hit);
					hit_count++;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// watch config writes, results and accepted items at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now = '0;
			lifetime = LIFETIME_RESET;
			live_records.delete();
			expected_outcomes.delete();
			pending = 0;
		end else begin
			if (cfg_we === 1'b1)
				lifetime = cfg_wdata;

			if (done === 1'b1) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					oldest = expected_outcomes.pop_front();
					if (found !== oldest.found)
						report_mismatch($sformatf("found %b, expected %b",
							found, oldest.found));
					if (category_out !== oldest.category)
						report_mismatch($sformatf("category_out %h, expected %h",
							category_out, oldest.category));
					if (head_flag_out !== oldest.head_flag)
						report_mismatch($sformatf("head_flag_out %b, expected %b",
							head_flag_out, oldest.head_flag));
					if (status !== oldest.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, oldest.status));
				end
			end

			if (start === 1'b1 && busy === 1'b0) begin
				expected_outcomes.insert(expected_outcomes.size(),
					match_table_step(cmd_t'(cmd), aggressor_id, target_id,
					category_in, head_flag_in));
				items_seen++;
			end
			pending = expected_outcomes.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/timed_pending_match_table_top_tb.sv
// testbench top for the timed pending match table: clock, reset, directed and
// random items over several lifetime settings, and the final verdict
// depends on tpmt_pkg, timed_pending_match_table_top and tpmt_result_checker
`default_nettype none

module timed_pending_match_table_top_tb;
	import tpmt_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0] aggressor;
		logic [ID_W-1:0] target;
	} id_pair_t;

	localparam int PHASES = 6;
	localparam logic [LIFE_W-1:0] PHASE_LIFETIME [PHASES] =
		'{32'd5, 32'd1, 32'hFFFF_FFFF, 32'd60, 32'd0, 32'd17};
	localparam int PHASE_IDLE_PCT [PHASES] = '{0, 71, 25, 0, 71, 25};
	localparam int PHASE_ITEMS [PHASES]    = '{340, 340, 340, 340, 150, 340};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [LIFE_W-1:0] cfg_wdata    = '0;
	logic              start        = 1'b0;
	logic [1:0]        cmd          = CMD_TICK;
	logic [ID_W-1:0]   aggressor_id = '0;
	logic [ID_W-1:0]   target_id    = '0;
	logic [CAT_W-1:0]  category_in  = '0;
	logic              head_flag_in = 1'b0;
	logic              busy;
	logic              done;
	logic              found;
	logic [CAT_W-1:0]  category_out;
	logic              head_flag_out;
	logic [1:0]        status;

	int fail_count;
	int pending;
	int items_seen;
	int hit_count;
	int drop_count;
	int purge_count;

	id_pair_t recent_pushes[$];

	always #1 clk = ~clk;

	timed_pending_match_table_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.aggressor_id  (aggressor_id),
		.target_id     (target_id),
		.category_in   (category_in),
		.head_flag_in  (head_flag_in),
		.done          (done),
		.found         (found),
		.category_out  (category_out),
		.head_flag_out (head_flag_out),
		.status        (status)
	);

	tpmt_result_checker match_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.aggressor_id  (aggressor_id),
		.target_id     (target_id),
		.category_in   (category_in),
		.head_flag_in  (head_flag_in),
		.done          (done),
		.found         (found),
		.category_out  (category_out),
		.head_flag_out (head_flag_out),
		.status        (status),
		.fail_count    (fail_count),
		.pending       (pending),
		.items_seen    (items_seen),
		.hit_count     (hit_count),
		.drop_count    (drop_count),
		.purge_count   (purge_count)
	);

	// present one item at a falling edge and hold it until accepted
	task automatic send_item(input cmd_t op, input logic [ID_W-1:0] aggr,
			input logic [ID_W-1:0] targ, input logic [CAT_W-1:0] cat, input logic head);
		start        = 1'b1;
		cmd          = op;
		aggressor_id = aggr;
		target_id    = targ;
		category_in  = cat;
		head_flag_in = head;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	// stop sending and wait until every outstanding item has its result
	task automatic wait_drained();
		start = 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_lifetime(input logic [LIFE_W-1:0] value);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// random sender gaps, now and then a long one
	task automatic hold_off(input int pct);
		if (pct > 0) begin
			while ($urandom_range(99) < pct) begin
				start = 1'b0;
				@(negedge clk);
			end
			if ($urandom_range(49) == 0) begin
				start = 1'b0;
				repeat ($urandom_range(40, 10)) @(negedge clk);
			end
		end
	endtask

	// mostly a few small ids so that consumes find matches
	function automatic logic [ID_W-1:0] pick_target();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		if (r < 20)
			return $urandom();
		return $urandom_range(6, 1);
	endfunction

	function automatic logic [ID_W-1:0] pick_aggressor();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return '0;
		if (r < 40)
			return $urandom();
		if (r < 45)
			return '1;
		return $urandom_range(4, 1);
	endfunction

	// one random item: ticks, pushes, consumes aimed at recent pushes, unused commands
	task automatic random_item();
		int              r;
		id_pair_t        pick;
		logic [ID_W-1:0] aggr;
		logic [ID_W-1:0] targ;
		r = $urandom_range(99);
		if (r < 22) begin
			send_item(CMD_TICK, $urandom(), $urandom(), CAT_W'($urandom_range(255)),
				1'($urandom_range(1)));
		end else if (r < 58) begin
			aggr = pick_aggressor();
			targ = pick_target();
			send_item(CMD_PUSH, aggr, targ, CAT_W'($urandom_range(255)),
				1'($urandom_range(1)));
			if (targ != '0) begin
				pick.aggressor = aggr;
				pick.target    = targ;
				recent_pushes.insert(recent_pushes.size(), pick);
				if (recent_pushes.size() > 8)
					void'(recent_pushes.pop_front());
			end
		end else if (r < 95) begin
			if (recent_pushes.size() > 0 && $urandom_range(99) < 70) begin
				pick = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
				targ = pick.target;
				aggr = (pick.aggressor == '0) ? pick_aggressor() : pick.aggressor;
			end else begin
				aggr = pick_aggressor();
				targ = pick_target();
			end
			send_item(CMD_CONSUME, aggr, targ, CAT_W'($urandom_range(255)),
				1'($urandom_range(1)));
		end else begin
			send_item(CMD_NONE, $urandom(), $urandom(), CAT_W'($urandom_range(255)),
				1'($urandom_range(1)));
		end
	endtask

	// stimulus
	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, zero targets, unused command, wildcard and exact match
		send_item(CMD_CONSUME, 32'd0, 32'd1, 8'h00, 1'b0);
		send_item(CMD_PUSH, 32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b1);
		send_item(CMD_CONSUME, 32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b1);
		send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send_item(CMD_PUSH, 32'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send_item(CMD_PUSH, 32'd5, 32'd1, 8'hA5, 1'b0);
		send_item(CMD_CONSUME, 32'd9, 32'd1, 8'h00, 1'b0);
		send_item(CMD_CONSUME, 32'd5, 32'd1, 8'h00, 1'b0);
		send_item(CMD_CONSUME, 32'd123, 32'hFFFF_FFFF, 8'h00, 1'b0);
		send_item(CMD_TICK, 32'd0, 32'd0, 8'h00, 1'b0);

		// directed: fill with one-tick records, overflow by one, then let all expire
		write_lifetime(32'd1);
		for (int i = 0; i <= TABLE_DEPTH; i++)
			send_item(CMD_PUSH, $urandom(), 32'd2, CAT_W'($urandom_range(255)),
				1'($urandom_range(1)));
		send_item(CMD_TICK, 32'd0, 32'd0, 8'h00, 1'b0);

		// random phases over several lifetimes and sender gap rates
		for (int p = 0; p < PHASES; p++) begin
			write_lifetime(PHASE_LIFETIME[p]);
			recent_pushes.delete();
			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				hold_off(PHASE_IDLE_PCT[p]);
				if ($urandom_range(199) == 0)
					wait_drained();
				random_item();
			end
		end

		wait_drained();
		repeat (25) @(negedge clk);

		$display("covered %0d items over %0d lifetime settings: %0d consumes matched,",
			items_seen, PHASES + 2, hit_count);
		$display("%0d pushes dropped on a full table, %0d records expired", drop_count,
			purge_count);
		if (fail_count == 0 && pending == 0)
			$display("timed_pending_match_table_top_tb OK");
		else
			$display("timed_pending_match_table_top_tb NOT OK");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#2000000;
		$display("timed_pending_match_table_top_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/tpmt_pkg.sv
src/timed_pending_match_table_top.sv
tb/tpmt_result_checker.sv
tb/timed_pending_match_table_top_tb.sv
